### hdl/amf0_pkg.sv
// Shared types and codes for the AMF0 script-data parser.
// No dependencies; RTL files use scoped names, the testbench imports it.
package amf0_pkg;

  typedef enum logic [3:0] {
    EV_NONE       = 4'd0,
    EV_NAME_CHAR  = 4'd1,
    EV_ARR_COUNT  = 4'd2,
    EV_KEY_CHAR   = 4'd3,
    EV_KEY_DONE   = 4'd4,
    EV_NUMBER     = 4'd5,
    EV_BOOLEAN    = 4'd6,
    EV_STR_CHAR   = 4'd7,
    EV_STR_DONE   = 4'd8,
    EV_OBJ_END    = 4'd9,
    EV_ERROR      = 4'd10
  } event_t;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_NOT_ARRAY = 2'd1;
  localparam logic [1:0] ERR_BAD_TYPE  = 2'd2;
  localparam logic [1:0] ERR_BAD_END   = 2'd3;

  localparam logic [7:0] ECMA_ARRAY_MARK = 8'd8;
  localparam logic [7:0] OBJ_END_MARK    = 8'd9;
  localparam logic [7:0] TYPE_NUMBER     = 8'd0;
  localparam logic [7:0] TYPE_BOOLEAN    = 8'd1;
  localparam logic [7:0] TYPE_STRING     = 8'd2;

  localparam int TDATA_OUT_W = 80;

  typedef struct packed {
    logic       start;
    logic [7:0] data;
  } in_word_t;

  typedef struct packed {
    event_t      ev;
    logic [7:0]  ch;
    logic [63:0] val;
    logic [1:0]  err;
  } result_t;

endpackage

### hdl/amf0_in_reg.sv
// Input register stage of the AMF0 parser: captures one word per handshake.
// Depends on amf0_pkg.
module amf0_in_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  amf0_pkg::in_word_t s_word,
  input  logic               advance,
  output logic               valid,
  output amf0_pkg::in_word_t word
);

  assign s_tready = !valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_tready) begin
      valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      word <= s_word;
    end
  end

endmodule

### hdl/amf0_step.sv
// Parser state and per-byte step logic of the AMF0 parser.
// Depends on amf0_pkg; state advances only when a word moves to the result stage.
module amf0_step (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  amf0_pkg::in_word_t word,
  output amf0_pkg::result_t  result
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_NAME_HI, PH_NAME_LO, PH_NAME_CHR,
    PH_ARR_TYPE, PH_COUNT, PH_KEY_HI, PH_KEY_LO,
    PH_END_MARK, PH_KEY_CHR, PH_VAL_TYPE, PH_NUM,
    PH_BOOL, PH_STR_HI, PH_STR_LO, PH_STR_CHR
  } phase_t;

  phase_t      phase, phase_next;
  logic [15:0] byte_counter, byte_counter_next;
  logic [15:0] field_length, field_length_next;
  logic [63:0] value_shift, value_shift_next;

  logic [15:0] cnt_inc;
  logic [15:0] len_full;
  logic [63:0] shifted;
  logic        at_end;

  assign cnt_inc  = byte_counter + 16'd1;
  assign len_full = {field_length[15:8], word.data};
  assign shifted  = {value_shift[55:0], word.data};
  assign at_end   = cnt_inc >= field_length;

  always_comb begin
    phase_next        = phase;
    byte_counter_next = byte_counter;
    field_length_next = field_length;
    value_shift_next  = value_shift;
    result.ev  = amf0_pkg::EV_NONE;
    result.ch  = 8'd0;
    result.val = 64'd0;
    result.err = amf0_pkg::ERR_NONE;
    if (word.start) begin
      phase_next        = PH_NAME_HI;
      byte_counter_next = 16'd0;
      field_length_next = 16'd0;
      value_shift_next  = 64'd0;
    end else begin
      unique case (phase)
        PH_NAME_HI, PH_KEY_HI, PH_STR_HI: begin
          field_length_next = {word.data, 8'd0};
          phase_next        = phase_t'(phase + 4'd1);
        end
        PH_NAME_LO: begin
          field_length_next = len_full;
          byte_counter_next = 16'd0;
          phase_next        = (len_full != 16'd0) ? PH_NAME_CHR : PH_ARR_TYPE;
        end
        PH_NAME_CHR: begin
          result.ev = amf0_pkg::EV_NAME_CHAR;
          result.ch = word.data;
          byte_counter_next = cnt_inc;
          if (at_end) phase_next = PH_ARR_TYPE;
        end
        PH_ARR_TYPE: begin
          if (word.data == amf0_pkg::ECMA_ARRAY_MARK) begin
            phase_next        = PH_COUNT;
            byte_counter_next = 16'd0;
            value_shift_next  = 64'd0;
          end else begin
            result.ev  = amf0_pkg::EV_ERROR;
            result.err = amf0_pkg::ERR_NOT_ARRAY;
            phase_next = PH_IDLE;
          end
        end
        PH_COUNT: begin
          value_shift_next  = shifted;
          byte_counter_next = cnt_inc;
          if (cnt_inc >= 16'd4) begin
            result.ev  = amf0_pkg::EV_ARR_COUNT;
            result.val = {32'd0, shifted[31:0]};
            phase_next = PH_KEY_HI;
          end
        end
        PH_KEY_LO: begin
          field_length_next = len_full;
          byte_counter_next = 16'd0;
          phase_next        = (len_full != 16'd0) ? PH_KEY_CHR : PH_END_MARK;
        end
        PH_END_MARK: begin
          if (word.data == amf0_pkg::OBJ_END_MARK) begin
            result.ev = amf0_pkg::EV_OBJ_END;
          end else begin
            result.ev  = amf0_pkg::EV_ERROR;
            result.err = amf0_pkg::ERR_BAD_END;
          end
          phase_next = PH_IDLE;
        end
        PH_KEY_CHR: begin
          result.ch = word.data;
          byte_counter_next = cnt_inc;
          if (at_end) begin
            result.ev  = amf0_pkg::EV_KEY_DONE;
            phase_next = PH_VAL_TYPE;
          end else begin
            result.ev = amf0_pkg::EV_KEY_CHAR;
          end
        end
        PH_VAL_TYPE: begin
          priority if (word.data == amf0_pkg::TYPE_NUMBER) begin
            phase_next        = PH_NUM;
            byte_counter_next = 16'd0;
            value_shift_next  = 64'd0;
          end else if (word.data == amf0_pkg::TYPE_BOOLEAN) begin
            phase_next = PH_BOOL;
          end else if (word.data == amf0_pkg::TYPE_STRING) begin
            phase_next = PH_STR_HI;
          end else begin
            result.ev  = amf0_pkg::EV_ERROR;
            result.err = amf0_pkg::ERR_BAD_TYPE;
            phase_next = PH_IDLE;
          end
        end
        PH_NUM: begin
          value_shift_next  = shifted;
          byte_counter_next = cnt_inc;
          if (cnt_inc >= 16'd8) begin
            result.ev  = amf0_pkg::EV_NUMBER;
            result.val = shifted;
            phase_next = PH_KEY_HI;
          end
        end
        PH_BOOL: begin
          result.ev  = amf0_pkg::EV_BOOLEAN;
          result.val = {56'd0, word.data};
          phase_next = PH_KEY_HI;
        end
        PH_STR_LO: begin
          field_length_next = len_full;
          byte_counter_next = 16'd0;
          if (len_full != 16'd0) begin
            phase_next = PH_STR_CHR;
          end else begin
            result.ev  = amf0_pkg::EV_STR_DONE;
            phase_next = PH_KEY_HI;
          end
        end
        PH_STR_CHR: begin
          result.ch = word.data;
          byte_counter_next = cnt_inc;
          if (at_end) begin
            result.ev  = amf0_pkg::EV_STR_DONE;
            phase_next = PH_KEY_HI;
          end else begin
            result.ev = amf0_pkg::EV_STR_CHAR;
          end
        end
        PH_IDLE: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      byte_counter <= 16'd0;
      field_length <= 16'd0;
      value_shift  <= 64'd0;
    end else if (fire) begin
      phase        <= phase_next;
      byte_counter <= byte_counter_next;
      field_length <= field_length_next;
      value_shift  <= value_shift_next;
    end
  end

endmodule

### hdl/amf0_out_reg.sv
// Result register stage of the AMF0 parser: holds one result word until taken.
// Depends on amf0_pkg.
module amf0_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic              in_valid,
  input  amf0_pkg::result_t in_result,
  output logic              valid,
  output amf0_pkg::result_t result
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid <= in_valid;
    end
    if (advance && in_valid) begin
      result <= in_result;
    end
  end

endmodule

### hdl/amf0_script_data_parser.sv
// Top level of the AMF0 script-data parser: input stage, step logic, result stage.
// Depends on amf0_pkg, amf0_in_reg, amf0_step and amf0_out_reg.
//
// Usage:
//   The slave stream carries one byte of FLV script-data body per word;
//   s_tuser high marks the first type byte of a record and restarts parsing.
//   The master stream returns exactly one result word per input word:
//   m_tuser is the event code, m_tdata carries the character, the value
//   (array count, raw double bits or boolean byte) and the error code.
// Path: an accepted word waits in the input register until the result stage
//   advances, then passes through the step logic into the result register.
// Throughput: one word per cycle unless m_tready stalls, set by the single
//   pass through the step logic between the two registers; the parser state
//   updates once per word.
// Reset: synchronous rst empties both stages and returns the parser to idle;
//   bytes before the first start flag give the "none" event.
// Stall: when m_tready is low, the result is held and the input stage keeps
//   accepting until it is full; s_tready then drops until the result is taken.
// Errors and the object end stop parsing; later bytes give the "none" event
//   until the next start flag.
module amf0_script_data_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // [0] start_of_record
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,   // [7:0] char_byte, [71:8] value_word,
                                 // [73:72] error_code, [79:74] zero
  output logic [3:0]  m_tuser    // [3:0] event_res
);

  amf0_pkg::in_word_t s_word;
  amf0_pkg::in_word_t in_word;
  amf0_pkg::result_t  step_result;
  amf0_pkg::result_t  out_result;
  logic               in_valid;
  logic               advance;
  logic               fire;

  // Advance the pipe whenever the result stage is empty or being drained.
  assign advance = !m_tvalid || m_tready;
  assign fire    = in_valid && advance;

  assign s_word.start = s_tuser;
  assign s_word.data  = s_tdata;

  amf0_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_word   (s_word),
    .advance  (advance),
    .valid    (in_valid),
    .word     (in_word)
  );

  // Update the parser state only when the word leaves the input stage.
  amf0_step u_step (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .word   (in_word),
    .result (step_result)
  );

  amf0_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_valid  (in_valid),
    .in_result (step_result),
    .valid     (m_tvalid),
    .result    (out_result)
  );

  // Pack the result word, lowest field first, pad to whole bytes.
  assign m_tdata = {6'd0, out_result.err, out_result.val, out_result.ch};
  assign m_tuser = out_result.ev;

endmodule

### hdl/amf0_checker.sv
// Port-level checks for the AMF0 script-data parser, bound to the top level.
// Depends on amf0_pkg and amf0_script_data_parser.
module amf0_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [79:0] m_tdata,
  input logic [3:0]  m_tuser
);

  // Nothing leaves the block right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // A stalled result word holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // An error code appears exactly with the error event.
  a_err_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tuser == amf0_pkg::EV_ERROR) == (m_tdata[73:72] != 2'd0)))
    else $error("error code does not match event");

  // A none event carries an all-zero payload.
  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == amf0_pkg::EV_NONE |-> m_tdata == 80'd0)
    else $error("none event with payload");

  // The input side is never blocked while the result stage is free.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty result stage");

endmodule

bind amf0_script_data_parser amf0_checker u_amf0_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

### tb/sv/tb.sv
// Self-checking testbench for amf0_script_data_parser: streams script-data words,
// predicts one result word per input word and compares every field on the master side.
// Depends on amf0_pkg and the amf0_script_data_parser RTL.
module tb;
  import amf0_pkg::*;

  // Cycles with no word moving on either side before the run is declared hung.
  localparam int IDLE_LIMIT = 500;
  // Input register plus result register, with margin.
  localparam int DRAIN_CYCLES = 8;

  // Parser phases of the prediction; same progression as the RTL.
  typedef enum logic [3:0] {
    P_IDLE, P_NAME_HI, P_NAME_LO, P_NAME_CHR, P_ARR_TYPE, P_COUNT,
    P_KEY_HI, P_KEY_LO, P_END_MARK, P_KEY_CHR, P_VAL_TYPE, P_NUM,
    P_BOOL, P_STR_HI, P_STR_LO, P_STR_CHR
  } parse_phase_t;

  // Ways a random record is damaged on purpose.
  typedef enum int {
    FLAW_NONE, FLAW_NOT_ARRAY, FLAW_BAD_TYPE, FLAW_BAD_END, FLAW_CUT
  } flaw_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;
  logic [3:0]  m_tuser;

  // Predicted parser state, reset values as after rst.
  parse_phase_t phase_q = P_IDLE;
  logic [15:0]  count_q = '0;
  logic [15:0]  len_q = '0;
  logic [63:0]  shift_q = '0;

  result_t     results_due[$];   // predicted result words, oldest first
  logic [8:0]  record_q[$];      // {start, byte} words waiting to be sent
  int          words_sent = 0;
  int          results_seen = 0;
  int          mismatches = 0;
  int          idle_cycles = 0;
  bit          no_idle = 1'b0;   // set to run both sides back to back

  always #6 clk = ~clk;

  amf0_script_data_parser dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // Advance the predicted parser by one byte and queue the result word it yields.
  task automatic parse_byte(input logic [7:0] b, input logic sor);
    result_t r;
    r.ev  = EV_NONE;
    r.ch  = 8'h00;
    r.val = 64'd0;
    r.err = ERR_NONE;
    if (sor) begin
      // Restart: this byte is the record's type byte and is not checked.
      phase_q = P_NAME_HI;
      count_q = '0;
      len_q   = '0;
      shift_q = '0;
    end else begin
      case (phase_q)
        P_NAME_HI: begin
          len_q = {b, 8'h00};
          phase_q = P_NAME_LO;
        end
        P_KEY_HI: begin
          len_q = {b, 8'h00};
          phase_q = P_KEY_LO;
        end
        P_STR_HI: begin
          len_q = {b, 8'h00};
          phase_q = P_STR_LO;
        end
        P_NAME_LO: begin
          len_q = len_q | {8'h00, b};
          count_q = '0;
          // An empty name goes straight to the array type byte.
          if (len_q != 0) phase_q = P_NAME_CHR;
          else phase_q = P_ARR_TYPE;
        end
        P_NAME_CHR: begin
          r.ev = EV_NAME_CHAR;
          r.ch = b;
          count_q++;
          if (count_q >= len_q) phase_q = P_ARR_TYPE;
        end
        P_ARR_TYPE: begin
          if (b == ECMA_ARRAY_MARK) begin
            phase_q = P_COUNT;
            count_q = '0;
            shift_q = '0;
          end else begin
            r.ev = EV_ERROR;
            r.err = ERR_NOT_ARRAY;
            phase_q = P_IDLE;
          end
        end
        P_COUNT: begin
          shift_q = {shift_q[55:0], b};
          count_q++;
          if (count_q >= 16'd4) begin
            r.ev = EV_ARR_COUNT;
            r.val = {32'd0, shift_q[31:0]};
            phase_q = P_KEY_HI;
          end
        end
        P_KEY_LO: begin
          len_q = len_q | {8'h00, b};
          count_q = '0;
          // A zero key length announces the end marker.
          if (len_q != 0) phase_q = P_KEY_CHR;
          else phase_q = P_END_MARK;
        end
        P_END_MARK: begin
          if (b == OBJ_END_MARK) begin
            r.ev = EV_OBJ_END;
          end else begin
            r.ev = EV_ERROR;
            r.err = ERR_BAD_END;
          end
          phase_q = P_IDLE;
        end
        P_KEY_CHR: begin
          r.ch = b;
          count_q++;
          // The last key character carries the key done event.
          if (count_q >= len_q) begin
            r.ev = EV_KEY_DONE;
            phase_q = P_VAL_TYPE;
          end else begin
            r.ev = EV_KEY_CHAR;
          end
        end
        P_VAL_TYPE: begin
          if (b == TYPE_NUMBER) begin
            phase_q = P_NUM;
            count_q = '0;
            shift_q = '0;
          end else if (b == TYPE_BOOLEAN) begin
            phase_q = P_BOOL;
          end else if (b == TYPE_STRING) begin
            phase_q = P_STR_HI;
          end else begin
            r.ev = EV_ERROR;
            r.err = ERR_BAD_TYPE;
            phase_q = P_IDLE;
          end
        end
        P_NUM: begin
          shift_q = {shift_q[55:0], b};
          count_q++;
          if (count_q >= 16'd8) begin
            r.ev = EV_NUMBER;
            r.val = shift_q;
            phase_q = P_KEY_HI;
          end
        end
        P_BOOL: begin
          r.ev = EV_BOOLEAN;
          r.val = {56'd0, b};
          phase_q = P_KEY_HI;
        end
        P_STR_LO: begin
          len_q = len_q | {8'h00, b};
          count_q = '0;
          // An empty string is done on its low length byte, with no character.
          if (len_q != 0) begin
            phase_q = P_STR_CHR;
          end else begin
            r.ev = EV_STR_DONE;
            phase_q = P_KEY_HI;
          end
        end
        P_STR_CHR: begin
          r.ch = b;
          count_q++;
          if (count_q >= len_q) begin
            r.ev = EV_STR_DONE;
            phase_q = P_KEY_HI;
          end else begin
            r.ev = EV_STR_CHAR;
          end
        end
        default: begin
          // Idle: before any start, or after an error or the object end.
        end
      endcase
    end
    results_due.push_back(r);
  endtask

  function automatic void push_byte(input logic [7:0] b, input logic sor);
    record_q.push_back({sor, b});
  endfunction

  // Append a big-endian 16-bit length.
  function automatic void push_len(input logic [15:0] n);
    push_byte(n[15:8], 1'b0);
    push_byte(n[7:0], 1'b0);
  endfunction

  function automatic void push_chars(input int n);
    repeat (n) push_byte(8'($urandom_range(0, 255)), 1'b0);
  endfunction

  // Drive one word and hold it until the parser takes it. Valid stays high after the
  // handshake so that a back-to-back word needs no second assignment in the same step.
  task automatic send_byte(input logic [7:0] b, input logic sor);
    int  gap;
    bit  took;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= sor;
    took = 1'b0;
    while (!took) begin
      // Sample ready mid-cycle, where it is stable; the word moves at the next edge.
      @(negedge clk);
      took = s_tready;
      if (took) parse_byte(b, sor);
      @(posedge clk);
    end
    words_sent++;
  endtask

  task automatic send_queued();
    logic [8:0] w;
    while (record_q.size() != 0) begin
      w = record_q.pop_front();
      send_byte(w[7:0], w[8]);
    end
  endtask

  // Build one record with random content, damaged as flaw asks.
  function automatic void build_record(input flaw_t flaw);
    int         n;
    int         n_props;
    int         bad_at;
    int         cut;
    logic [7:0] mark;
    push_byte(8'($urandom_range(0, 255)), 1'b1);
    n = $urandom_range(0, 3);
    push_len(16'(n));
    push_chars(n);
    if (flaw == FLAW_NOT_ARRAY) begin
      do mark = 8'($urandom_range(0, 255)); while (mark == ECMA_ARRAY_MARK);
      push_byte(mark, 1'b0);
    end else begin
      push_byte(ECMA_ARRAY_MARK, 1'b0);
    end
    push_chars(4);
    n_props = $urandom_range(0, 4);
    if (flaw == FLAW_BAD_TYPE && n_props == 0) n_props = 1;
    bad_at = $urandom_range(0, n_props - 1);
    for (int i = 0; i < n_props; i++) begin
      n = $urandom_range(1, 4);
      push_len(16'(n));
      push_chars(n);
      if (flaw == FLAW_BAD_TYPE && i == bad_at) begin
        // Parsing stops here; the trailing bytes are ignored.
        push_byte(8'($urandom_range(3, 255)), 1'b0);
        push_chars($urandom_range(0, 3));
        return;
      end
      case ($urandom_range(0, 2))
        0: begin
          push_byte(TYPE_NUMBER, 1'b0);
          push_chars(8);
        end
        1: begin
          push_byte(TYPE_BOOLEAN, 1'b0);
          push_chars(1);
        end
        default: begin
          push_byte(TYPE_STRING, 1'b0);
          n = $urandom_range(0, 4);
          push_len(16'(n));
          push_chars(n);
        end
      endcase
    end
    push_len(16'd0);
    if (flaw == FLAW_BAD_END) begin
      do mark = 8'($urandom_range(0, 255)); while (mark == OBJ_END_MARK);
      push_byte(mark, 1'b0);
    end else begin
      push_byte(OBJ_END_MARK, 1'b0);
    end
    push_chars($urandom_range(0, 2));
    if (flaw == FLAW_CUT) begin
      // Drop the tail so the next start flag lands in the middle of the record.
      cut = $urandom_range(1, record_q.size() - 1);
      while (record_q.size() > cut) record_q.delete(record_q.size() - 1);
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatches < 40)
      $display("result %0d: %s got %0h, expected %0h", results_seen, what, got, want);
    mismatches++;
  endtask

  // Compare a result word with the oldest prediction, field by field.
  task automatic check_result();
    result_t want;
    if (results_due.size() == 0) begin
      report_mismatch("result word with none due, event", 64'(m_tuser), 64'd0);
    end else begin
      want = results_due.pop_front();
      if (m_tuser !== want.ev)
        report_mismatch("event", 64'(m_tuser), 64'(want.ev));
      if (m_tdata[7:0] !== want.ch)
        report_mismatch("char", 64'(m_tdata[7:0]), 64'(want.ch));
      if (m_tdata[71:8] !== want.val)
        report_mismatch("value", m_tdata[71:8], want.val);
      if (m_tdata[73:72] !== want.err)
        report_mismatch("error code", 64'(m_tdata[73:72]), 64'(want.err));
    end
    results_seen++;
  endtask

  // Check at mid-cycle: the word is taken at the next rising edge.
  always @(negedge clk) begin
    if (!rst && m_tvalid && m_tready) check_result();
  end

  // Result side: insert a random stall before each result word, none when no_idle is set.
  initial begin : result_sink
    int stall;
    bit took;
    wait (!rst);
    @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 3);
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      took = 1'b0;
      while (!took) begin
        @(negedge clk);
        took = m_tvalid;
        @(posedge clk);
      end
    end
  end

  // Watchdog: end the run if no word moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Bytes before the first start flag give no event.
  task automatic test_ignored_before_start();
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    send_queued();
  endtask

  // Restart mid-record, then fail the array type; the byte after the error is ignored.
  task automatic test_restart_and_not_array();
    push_byte(8'h02, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b1);
    push_len(16'd0);
    push_byte(8'h03, 1'b0);
    push_byte(ECMA_ARRAY_MARK, 1'b0);
    send_queued();
  endtask

  // One-char name, full-scale count, a boolean of all ones, an empty string,
  // the object end and an ignored byte after it.
  task automatic test_full_object();
    push_byte(8'h02, 1'b1);
    push_len(16'd1);
    push_byte(8'h41, 1'b0);
    push_byte(ECMA_ARRAY_MARK, 1'b0);
    repeat (4) push_byte(8'hFF, 1'b0);
    push_len(16'd1);
    push_byte(8'h62, 1'b0);
    push_byte(TYPE_BOOLEAN, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_len(16'd1);
    push_byte(8'h65, 1'b0);
    push_byte(TYPE_STRING, 1'b0);
    push_len(16'd0);
    push_len(16'd0);
    push_byte(OBJ_END_MARK, 1'b0);
    push_byte(8'h55, 1'b0);
    send_queued();
  endtask

  // Mostly well-formed records with random content, some damaged, some pure noise.
  task automatic test_random_records(input int n_words);
    int target;
    int pick;
    target = words_sent + n_words;
    while (words_sent < target) begin
      no_idle = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        // Noise: random bytes with a rare start flag, long lengths included.
        repeat ($urandom_range(4, 12))
          push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      end else if (pick <= 3) begin
        build_record(flaw_t'($urandom_range(FLAW_NOT_ARRAY, FLAW_CUT)));
      end else begin
        build_record(FLAW_NONE);
      end
      send_queued();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_ignored_before_start();
    test_restart_and_not_array();
    test_full_object();
    test_random_records(600);
    s_tvalid <= 1'b0;
    // Drain: the watchdog catches any result word that never comes.
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
